### rtl/core/polynomial_pose_trajectory_generator_macros.svh
// Assertion helpers for the pose trajectory generator
`ifndef POLYNOMIAL_POSE_TRAJECTORY_GENERATOR_MACROS_SVH
`define POLYNOMIAL_POSE_TRAJECTORY_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define PPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ppt_pkg.sv
package ppt_pkg;

  // Fraction bits of the normalised time and of the profile value
  localparam int FRAC_BITS = 24;
  // Profile value reaches exactly one, so it needs one integer bit
  localparam int PROF_W    = FRAC_BITS + 1;
  // Product of a fraction-wide operand and a profile-wide operand
  localparam int PROD_W    = FRAC_BITS + PROF_W;

  localparam int POS_WIDTH_DEF  = 32;
  localparam int TICK_WIDTH_DEF = 24;

  // Configuration port
  localparam int CFG_AW       = 3;
  localparam int DURATION_RST = 10000;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Multiply-accumulate control from the sequencer
  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctrl_t;

endpackage

### rtl/core/ppt_div.sv
module ppt_div import ppt_pkg::*; #(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TICK_WIDTH-1:0] dividend_i,
  input  logic [TICK_WIDTH-1:0] divisor_i,
  output logic [FRAC_BITS-1:0]  quo_o,
  output div_stat_t             stat_o
);

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [TICK_WIDTH-1:0] rem_q;
  logic [TICK_WIDTH-1:0] den_q;
  logic [FRAC_BITS-1:0]  quo_q;
  logic [TICK_WIDTH:0]   rem2;
  logic [TICK_WIDTH:0]   diff;
  logic                  ge;

  // Restoring step: the remainder stays below the divisor, so doubling fits one extra bit
  assign rem2 = {rem_q, 1'b0};
  assign diff = rem2 - {1'b0, den_q};
  assign ge   = ~diff[TICK_WIDTH];

  // Step counter and handshake with the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TICK_WIDTH-1:0] : rem2[TICK_WIDTH-1:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], ge};
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### rtl/core/ppt_mac.sv
module ppt_mac import ppt_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_ctrl_t            ctrl_i,
  input  logic [FRAC_BITS-1:0] a_i,
  input  logic [PROF_W-1:0]    b_i,
  input  logic [((POS_WIDTH + FRAC_BITS - 1) / FRAC_BITS > 1 ?
                 $clog2((POS_WIDTH + FRAC_BITS - 1) / FRAC_BITS) : 1)-1:0] chunk_i,
  output logic [PROD_W-1:0]    prod_o,
  output logic [POS_WIDTH-1:0] acc_o
);

  localparam int NCHUNK = (POS_WIDTH + FRAC_BITS - 1) / FRAC_BITS;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int SH_W   = PROD_W + FRAC_BITS * (NCHUNK - 1);

  logic [PROD_W-1:0]    prod_q;
  logic [CW-1:0]        chunk_q;
  logic                 pend_q;
  logic [POS_WIDTH-1:0] acc_q;
  logic [SH_W-1:0]      term;

  // Place the partial product at its chunk weight, then drop the fraction bits
  assign term = (SH_W'(prod_q) << (FRAC_BITS * chunk_q)) >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctrl_i.issue;
    end
  end

  // Register the product, then accumulate it in the next cycle
  always_ff @(posedge clk_i) begin
    prod_q  <= a_i * b_i;
    chunk_q <= chunk_i;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (pend_q) begin
      acc_q <= acc_q + term[POS_WIDTH-1:0];
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

### rtl/core/polynomial_pose_trajectory_generator.sv
// Point-to-point pose trajectory generator. Each input beat is one control tick; while the
// tick count n is below duration_ticks T it returns start + (goal - start) * p(n/T) for x, y
// and heading (Q16.16, rounded toward zero, saturated), with p(s) = s^2 or 3s^2 - 2s^3, and
// then advances n; once n has reached T it returns the last pose with finished set. A beat
// with restart set clears n first. Configuration writes take effect on the next tick; they must
// be made only while the block is idle, which the block itself does not enforce. Every tick gives
// exactly one result beat. A moving tick goes first to the one-bit-per-cycle divider that forms
// n/T, then to a single registered 24 x 25 multiplier shared by s^2, s^3 and the partial
// products of each axis. A finished tick skips both and goes straight to the done state.
// The input is not ready while a tick is in work; a new tick is taken while the previous
// result still waits on the output.
`include "polynomial_pose_trajectory_generator_macros.svh"

module polynomial_pose_trajectory_generator import ppt_pkg::*; #(
  parameter int POS_WIDTH  = POS_WIDTH_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_AW-1:0]     cfg_addr_i,
  input  logic [((POS_WIDTH > TICK_WIDTH) ? POS_WIDTH : TICK_WIDTH)-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_WIDTH-1:0]  pos_x_o,
  output logic [POS_WIDTH-1:0]  pos_y_o,
  output logic [POS_WIDTH-1:0]  heading_o,
  output logic                  finished_o
);

  localparam int NCHUNK = (POS_WIDTH + FRAC_BITS - 1) / FRAC_BITS;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int MP_W   = NCHUNK * FRAC_BITS;
  localparam logic [CW-1:0] C_LAST = CW'(NCHUNK - 1);

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_START_X  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_START_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_START_H  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GOAL_X   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GOAL_Y   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_GOAL_H   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MODE     = 3'd6;
  localparam logic [CFG_AW-1:0] REG_DURATION = 3'd7;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIV   = 4'd1;
  localparam logic [3:0] ST_SQ    = 4'd2;
  localparam logic [3:0] ST_S3    = 4'd3;
  localparam logic [3:0] ST_PROF  = 4'd4;
  localparam logic [3:0] ST_PREP  = 4'd5;
  localparam logic [3:0] ST_MUL   = 4'd6;
  localparam logic [3:0] ST_DRAIN = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  // Axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_H = 2'd2;

  localparam logic [POS_WIDTH-1:0] SAT_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic [POS_WIDTH-1:0] SAT_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

  // Configuration registers
  logic [POS_WIDTH-1:0]  start_x_q, start_y_q, start_h_q;
  logic [POS_WIDTH-1:0]  goal_x_q, goal_y_q, goal_h_q;
  logic                  mode_q;
  logic [TICK_WIDTH-1:0] dur_q;

  // Sequencer and state
  logic [3:0]            state_q, state_d;
  logic [1:0]            ax_q;
  logic [CW-1:0]         c_q;
  logic                  fin_q;
  logic [TICK_WIDTH-1:0] tick_q;
  logic [POS_WIDTH-1:0]  held_x_q, held_y_q, held_h_q;
  logic                  out_valid_q;

  // Datapath registers
  logic [FRAC_BITS-1:0]  s2_q;
  logic [PROF_W-1:0]     p_q;
  logic [POS_WIDTH-1:0]  m_q;
  logic                  neg_q;
  logic [POS_WIDTH-1:0]  out_x_q, out_y_q, out_h_q;
  logic                  out_fin_q;

  logic                  in_acc;
  logic                  out_free;
  logic [TICK_WIDTH-1:0] n_eff;
  logic                  active;
  logic                  div_start;
  logic [FRAC_BITS-1:0]  quo;
  div_stat_t             div_stat;
  mac_ctrl_t             mac_ctrl;
  logic [FRAC_BITS-1:0]  mul_a;
  logic [PROF_W-1:0]     mul_b;
  logic [PROD_W-1:0]     prod;
  logic [POS_WIDTH-1:0]  acc;
  logic [FRAC_BITS-1:0]  s3;
  logic [PROF_W:0]       p_full;
  logic [POS_WIDTH-1:0]  st_sel, gl_sel;
  logic [POS_WIDTH:0]    d_pos, d_neg;
  logic                  neg_d;
  logic [POS_WIDTH-1:0]  m_d;
  logic [MP_W-1:0]       m_pad;
  logic [FRAC_BITS-1:0]  chunk;
  logic [POS_WIDTH+1:0]  sum;
  logic                  ovf;
  logic [POS_WIDTH-1:0]  res;

  // Handshake
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign n_eff      = restart_i ? '0 : tick_q;
  assign active     = (n_eff < dur_q);
  assign div_start  = in_acc & active;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      start_h_q <= '0;
      goal_x_q  <= '0;
      goal_y_q  <= '0;
      goal_h_q  <= '0;
      mode_q    <= 1'b1;
      dur_q     <= TICK_WIDTH'(DURATION_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_START_X:  start_x_q <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_START_Y:  start_y_q <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_START_H:  start_h_q <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_GOAL_X:   goal_x_q  <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_GOAL_Y:   goal_y_q  <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_GOAL_H:   goal_h_q  <= cfg_wdata_i[POS_WIDTH-1:0];
        REG_MODE:     mode_q    <= cfg_wdata_i[0];
        REG_DURATION: dur_q     <= cfg_wdata_i[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Normalised time n/T
  ppt_div #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_eff),
    .divisor_i  (dur_q),
    .quo_o      (quo),
    .stat_o     (div_stat)
  );

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = chunk;
    mul_b = p_q;
    case (state_q)
      ST_SQ: begin
        mul_a = quo;
        mul_b = {1'b0, quo};
      end
      ST_S3: begin
        mul_a = prod[2*FRAC_BITS-1:FRAC_BITS];
        mul_b = {1'b0, quo};
      end
      default: ;
    endcase
  end

  assign mac_ctrl.issue = (state_q == ST_MUL);
  assign mac_ctrl.clear = (state_q == ST_PREP);

  ppt_mac #(
    .POS_WIDTH (POS_WIDTH)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .chunk_i (c_q),
    .prod_o  (prod),
    .acc_o   (acc)
  );

  // Profile value from s^2 and s^3
  assign s3     = prod[2*FRAC_BITS-1:FRAC_BITS];
  assign p_full = mode_q ? ({1'b0, s2_q, 1'b0} + {2'b00, s2_q}) - {1'b0, s3, 1'b0}
                         : {2'b00, s2_q};

  // Start and goal of the axis in work
  always_comb begin
    st_sel = start_x_q;
    gl_sel = goal_x_q;
    unique case (ax_q)
      AX_X: begin
        st_sel = start_x_q;
        gl_sel = goal_x_q;
      end
      AX_Y: begin
        st_sel = start_y_q;
        gl_sel = goal_y_q;
      end
      AX_H: begin
        st_sel = start_h_q;
        gl_sel = goal_h_q;
      end
      default: ;
    endcase
  end

  // Magnitude and sign of goal - start
  assign d_pos = {gl_sel[POS_WIDTH-1], gl_sel} - {st_sel[POS_WIDTH-1], st_sel};
  assign d_neg = {st_sel[POS_WIDTH-1], st_sel} - {gl_sel[POS_WIDTH-1], gl_sel};
  assign neg_d = d_pos[POS_WIDTH];
  assign m_d   = neg_d ? d_neg[POS_WIDTH-1:0] : d_pos[POS_WIDTH-1:0];

  assign m_pad = MP_W'(m_q);
  assign chunk = m_pad[c_q*FRAC_BITS +: FRAC_BITS];

  // Apply the signed step and saturate
  assign sum = neg_q ? ({{2{st_sel[POS_WIDTH-1]}}, st_sel} - {2'b00, acc})
                     : ({{2{st_sel[POS_WIDTH-1]}}, st_sel} + {2'b00, acc});
  assign ovf = (sum[POS_WIDTH+1:POS_WIDTH-1] != 3'b000) &&
               (sum[POS_WIDTH+1:POS_WIDTH-1] != 3'b111);
  assign res = ovf ? (sum[POS_WIDTH+1] ? SAT_MIN : SAT_MAX) : sum[POS_WIDTH-1:0];

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = active ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_stat.done) state_d = ST_SQ;
      ST_SQ:    state_d = ST_S3;
      ST_S3:    state_d = ST_PROF;
      ST_PROF:  state_d = ST_PREP;
      ST_PREP:  state_d = ST_MUL;
      ST_MUL:   if (c_q == C_LAST) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_FIN;
      ST_FIN:   state_d = (ax_q == AX_H) ? ST_DONE : ST_PREP;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state, held pose and tick count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= AX_X;
      c_q         <= '0;
      fin_q       <= 1'b0;
      tick_q      <= '0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_h_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        fin_q <= ~active;
        if (restart_i) begin
          tick_q <= '0;
        end
      end
      if (state_q == ST_PROF) begin
        ax_q <= AX_X;
      end
      if (state_q == ST_PREP) begin
        c_q <= '0;
      end
      if (state_q == ST_MUL) begin
        c_q <= c_q + CW'(1);
      end
      if (state_q == ST_FIN) begin
        unique case (ax_q)
          AX_X:    held_x_q <= res;
          AX_Y:    held_y_q <= res;
          AX_H:    held_h_q <= res;
          default: ;
        endcase
        ax_q <= ax_q + 2'd1;
      end
      // Advance the tick of a moving beat and hand the result to the output
      if (state_q == ST_DONE && out_free) begin
        if (!fin_q) begin
          tick_q <= tick_q + TICK_WIDTH'(1);
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_S3) begin
      s2_q <= prod[2*FRAC_BITS-1:FRAC_BITS];
    end
    if (state_q == ST_PROF) begin
      p_q <= p_full[PROF_W-1:0];
    end
    if (state_q == ST_PREP) begin
      m_q   <= m_d;
      neg_q <= neg_d;
    end
    if (state_q == ST_DONE && out_free) begin
      out_x_q   <= held_x_q;
      out_y_q   <= held_y_q;
      out_h_q   <= held_h_q;
      out_fin_q <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign heading_o   = out_h_q;
  assign finished_o  = out_fin_q;

  `PPT_ASSERT_IMP(a_div_in_phase, clk_i, rst_ni, div_stat.busy, state_q == ST_DIV, "divider busy outside divide phase")
  `PPT_ASSERT_NXT(a_div_done_seq, clk_i, rst_ni, div_stat.done, state_q == ST_SQ, "divider finished while sequencer elsewhere")
  `PPT_ASSERT_NXT(a_tick_advance, clk_i, rst_ni, state_q == ST_DONE && out_free && !fin_q, tick_q == $past(tick_q) + TICK_WIDTH'(1), "tick count did not advance")
  `PPT_ASSERT_IMP(a_out_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q) == ST_DONE, "result beat raised outside done state")

endmodule

### tb/polynomial_pose_trajectory_generator_tb.sv
module polynomial_pose_trajectory_generator_tb;
  import ppt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [CFG_AW-1:0] {
    REG_START_X,
    REG_START_Y,
    REG_START_HEADING,
    REG_GOAL_X,
    REG_GOAL_Y,
    REG_GOAL_HEADING,
    REG_PROFILE_MODE,
    REG_DURATION
  } cfg_reg_e;

  typedef enum bit {ROW_TICK, ROW_CFG} row_kind_e;

  localparam bit MODE_SQUARE = 1'b0;
  localparam bit MODE_CUBIC  = 1'b1;

  localparam logic [31:0] P_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] P_MIN = 32'h8000_0000;
  localparam logic [31:0] HD_S  = 32'h1234_5678;
  localparam logic [31:0] HD_G  = 32'hEDCB_A988;
  localparam logic [31:0] T_MAX = 32'h00FF_FFFF;

  localparam int RANDOM_TICKS = 1750;
  localparam int PLAN_LEN     = 43;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] h;
    logic        fin;
  } pose_t;

  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    idx;
    logic [31:0] data;
    bit          rs;
    bit          typed;
    pose_t       want;
  } plan_row_t;

  // Directed plan: typed poses only where the answer is plain (reset, start pose, zero duration)
  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b0}},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DURATION,      32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b1, 1'b1, '{32'h0, 32'h0, 32'h0, 1'b1}},
    '{ROW_CFG,  REG_START_X,       P_MAX, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_GOAL_X,        P_MIN, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_START_Y,       P_MIN, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_GOAL_Y,        P_MAX, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_START_HEADING, HD_S,  1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_GOAL_HEADING,  HD_G,  1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DURATION,      32'd1, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b1, 1'b1, '{P_MAX, P_MIN, HD_S, 1'b0}},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b1, '{P_MAX, P_MIN, HD_S, 1'b1}},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b1, '{P_MAX, P_MIN, HD_S, 1'b1}},
    '{ROW_CFG,  REG_DURATION,      T_MAX, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DURATION,      32'd5, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b1, 1'b1, '{P_MAX, P_MIN, HD_S, 1'b0}},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_PROFILE_MODE,  {31'h0, MODE_SQUARE}, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DURATION,      32'd6, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b1, 1'b1, '{P_MAX, P_MIN, HD_S, 1'b0}},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DURATION,      32'd2, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DURATION,      32'd7, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_PROFILE_MODE,  {31'h0, MODE_CUBIC}, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_START_X,       P_MIN, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_GOAL_X,        P_MAX, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DURATION,      32'd3, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b1, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_START_X,       32'h0, 1'b0, 1'b0, '0}
  };

  string field_name [4] = '{"pos_x", "pos_y", "heading", "finished"};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  cfg_reg_e    cfg_addr_i  = REG_START_X;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] pos_x_o;
  logic [31:0] pos_y_o;
  logic [31:0] heading_o;
  logic        finished_o;

  // Predictor copy of the registers and of the trajectory state
  logic [31:0] start_pose [3] = '{32'h0, 32'h0, 32'h0};
  logic [31:0] goal_pose  [3] = '{32'h0, 32'h0, 32'h0};
  logic [31:0] held_pose  [3] = '{32'h0, 32'h0, 32'h0};
  bit          cubic_mode = MODE_CUBIC;
  logic [23:0] dur_ticks  = 24'(DURATION_RST);
  logic [23:0] tick_n     = '0;

  pose_t pending_poses [$];

  int send_idle_pct = 15;
  int recv_idle_pct = 61;
  int err_count     = 0;
  int ticks_sent    = 0;
  int dir_ticks     = 0;
  int poses_seen    = 0;
  int fin_seen      = 0;
  int reg_writes    = 0;

  polynomial_pose_trajectory_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .heading_o   (heading_o),
    .finished_o  (finished_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns MISMATCH %s", $time, msg);
    err_count++;
  endtask

  // start + (goal - start) * prof, truncated toward zero and clamped to the pose range
  function automatic logic [31:0] scale_axis(logic [31:0] org, logic [31:0] dst,
                                             longint unsigned prof);
    longint base, span, moved;
    longint unsigned mag, part;
    base  = longint'($signed(org));
    span  = longint'($signed(dst)) - base;
    mag   = (span < 0) ? -span : span;
    part  = (mag >> FRAC_BITS) * prof + (((mag & 64'hFF_FFFF) * prof) >> FRAC_BITS);
    moved = (span < 0) ? base - longint'(part) : base + longint'(part);
    if (moved > 64'sd2147483647)
      return P_MAX;
    if (moved < -64'sd2147483648)
      return P_MIN;
    return moved[31:0];
  endfunction

  // One control tick: restart, then move along the profile or hold the last pose
  task automatic advance_setpoint(input bit rs, output pose_t res);
    longint unsigned frac, sq, cu, prof;
    if (rs)
      tick_n = '0;
    if (tick_n < dur_ticks) begin
      frac = (longint'(tick_n) << FRAC_BITS) / dur_ticks;
      sq   = (frac * frac) >> FRAC_BITS;
      cu   = (sq * frac) >> FRAC_BITS;
      prof = cubic_mode ? 3 * sq - 2 * cu : sq;
      for (int a = 0; a < 3; a++)
        held_pose[a] = scale_axis(start_pose[a], goal_pose[a], prof);
      tick_n  = tick_n + 24'd1;
      res.fin = 1'b0;
    end else begin
      res.fin = 1'b1;
    end
    res.x = held_pose[0];
    res.y = held_pose[1];
    res.h = held_pose[2];
  endtask

  // Drive one register write and mirror it in the predictor
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_START_X:       start_pose[0] = value;
      REG_START_Y:       start_pose[1] = value;
      REG_START_HEADING: start_pose[2] = value;
      REG_GOAL_X:        goal_pose[0]  = value;
      REG_GOAL_Y:        goal_pose[1]  = value;
      REG_GOAL_HEADING:  goal_pose[2]  = value;
      REG_PROFILE_MODE:  cubic_mode    = value[0];
      REG_DURATION:      dur_ticks     = value[23:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Drop valid and hold off until every pose in flight has come back
  task automatic wait_idle();
    if (in_valid_i)
      @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_poses.size() != 0)
      @(posedge clk_i);
  endtask

  // Offer one tick beat, wait for acceptance and queue its expected pose
  task automatic send_tick(input bit rs, input bit typed, input pose_t want);
    pose_t res;
    while ($urandom_range(99) < send_idle_pct)
      @(negedge clk_i) in_valid_i <= 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    advance_setpoint(rs, res);
    pending_poses.push_back(typed ? want : res);
    ticks_sent++;
  endtask

  // Receiver stalls at random
  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  // Compare each pose beat against the oldest expectation
  always @(posedge clk_i) begin : check_pose
    pose_t       want;
    logic [31:0] got_f  [4];
    logic [31:0] want_f [4];
    if (rst_ni && out_valid_o && out_ready_i) begin
      poses_seen++;
      if (finished_o === 1'b1)
        fin_seen++;
      if (pending_poses.size() == 0) begin
        report_mismatch($sformatf("unexpected pose beat x=%h y=%h h=%h fin=%b",
                                  pos_x_o, pos_y_o, heading_o, finished_o));
      end else begin
        want      = pending_poses.pop_front();
        got_f     = '{pos_x_o, pos_y_o, heading_o, {31'h0, finished_o}};
        want_f    = '{want.x, want.y, want.h, {31'h0, want.fin}};
        for (int f = 0; f < 4; f++)
          if (got_f[f] !== want_f[f])
            report_mismatch($sformatf("beat %0d %s: got %h want %h", poses_seen,
                                      field_name[f], got_f[f], want_f[f]));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          rand_sent;
    int          batch;
    bit          first_phase;
    logic [31:0] value;
    rand_sent   = 0;
    first_phase = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Walk the directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].rs, plan[i].typed, plan[i].want);
        dir_ticks++;
      end
    end

    // Random moves: fresh registers, then a run of ticks with the odd restart
    while (rand_sent < RANDOM_TICKS) begin
      if (rand_sent < RANDOM_TICKS / 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 61;
      end else if (rand_sent < 2 * RANDOM_TICKS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_idle();
      for (int r = 0; r < 8; r++) begin
        if (first_phase || $urandom_range(9) < 7) begin
          case (cfg_reg_e'(r))
            REG_PROFILE_MODE: value = {31'h0, 1'($urandom_range(1))};
            REG_DURATION: begin
              case ($urandom_range(19))
                0:       value = 32'h0;
                1:       value = T_MAX;
                2:       value = $urandom_range(1, 24'hFF_FFFF);
                default: value = $urandom_range(1, 30);
              endcase
            end
            default: begin
              case ($urandom_range(5))
                0:       value = P_MAX;
                1:       value = P_MIN;
                2:       value = 32'h0;
                3:       value = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                default: value = $urandom;
              endcase
            end
          endcase
          write_reg(cfg_reg_e'(r), value);
        end
      end
      first_phase = 1'b0;
      batch = $urandom_range(4, 40);
      for (int k = 0; k < batch; k++) begin
        send_tick((k == 0) ? ($urandom_range(1) == 1) : ($urandom_range(9) == 0),
                  1'b0, '0);
        rand_sent++;
      end
    end

    // Drain, then allow for a late stray beat
    wait_idle();
    repeat (60) @(posedge clk_i);
    if (pending_poses.size() != 0)
      report_mismatch($sformatf("%0d expected poses never arrived", pending_poses.size()));

    $display("Sent %0d ticks (%0d directed) over %0d register writes", ticks_sent,
             dir_ticks, reg_writes);
    $display("Checked %0d pose beats, %0d of them with the move finished", poses_seen,
             fin_seen);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/ppt_pkg.sv
rtl/core/ppt_div.sv
rtl/core/ppt_mac.sv
rtl/core/polynomial_pose_trajectory_generator.sv
tb/polynomial_pose_trajectory_generator_tb.sv
